// ===== hw/rtl/lobm_pkg.sv =====
// Shared types and constants for the limit order book matcher.
package lobm_pkg;

    localparam int BOOK_DEPTH_DEF   = 63;
    localparam int MAX_MESSAGES_DEF = 1024;

    localparam int QTY_W   = 16;
    localparam int PRICE_W = 17;
    localparam int TOTAL_W = 22;
    localparam int TGT_W   = 11;

    localparam logic [PRICE_W-1:0] NO_ASK_PRICE = 17'd99999;
    localparam logic [PRICE_W-1:0] TOP_PRICE    = 17'd99998;

    localparam logic [1:0] OP_BUY    = 2'd0;
    localparam logic [1:0] OP_SELL   = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Side codes kept in the order table.
    localparam logic [1:0] SIDE_BUY  = 2'd0;
    localparam logic [1:0] SIDE_SELL = 2'd1;
    localparam logic [1:0] SIDE_NONE = 2'd2;

    localparam int RESULT_LIMIT = 64;

endpackage

// ===== hw/rtl/limit_order_book_matcher.sv =====
// Top level of the limit order book matcher: sequencer, books and order table.
// Each message is handled one at a time, and the input is ready only while the
// block is idle, so a new item is taken only after the quote item of the previous
// message has been taken. The books live in two RAMs and are walked one entry per
// cycle over the occupied entries only. One pass over both sides finds the best
// order and level total on each side. A buy or sell rests in its book, records
// itself in the order table, then runs one pass per fill; each fill offers the
// trade item, holds until it is taken, writes both best orders back and removes
// every order it empties. When the book stops crossing with both sides still
// occupied, one further pass builds the quote; when a side runs empty, the quote
// comes from the next pass directly. An accepted cancel of a live order clears
// its table entry, scans the target's side, records itself and removes the order;
// another accepted cancel, a zero-size message or one rejected for a full book
// only records itself. An ignored message, or one rejected for lack of ids, goes
// straight to the quote pass. The quote item is offered at the end of its pass
// and held until taken. No clearing pass is needed: book contents are tracked by
// counts, and the order table is read only for ids that have already been written.
module limit_order_book_matcher #(
    parameter int BOOK_DEPTH   = lobm_pkg::BOOK_DEPTH_DEF,
    parameter int MAX_MESSAGES = lobm_pkg::MAX_MESSAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [15:0] quantity,
    input  logic [16:0] limit_price,
    input  logic [10:0] cancel_target,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [15:0] trade_quantity,
    output logic [16:0] trade_price,
    output logic [21:0] bid_total,
    output logic [16:0] bid_price,
    output logic [21:0] ask_total,
    output logic [16:0] ask_price,
    output logic        rejected,
    output logic        last
);

    localparam int BW  = $clog2(BOOK_DEPTH);
    localparam int CW  = $clog2(BOOK_DEPTH + 1);
    localparam int TW  = $clog2(MAX_MESSAGES);
    localparam int IDW = ($clog2(MAX_MESSAGES + 1) > lobm_pkg::TGT_W)
                         ? $clog2(MAX_MESSAGES + 1) : lobm_pkg::TGT_W;
    localparam int EW  = IDW + lobm_pkg::QTY_W + lobm_pkg::PRICE_W;
    localparam int OW  = 2 + lobm_pkg::QTY_W;

    typedef struct packed {
        logic [IDW-1:0]              id;
        logic [lobm_pkg::QTY_W-1:0]   qty;
        logic [lobm_pkg::PRICE_W-1:0] price;
    } entry_t;

    typedef struct packed {
        logic [1:0]                 side;
        logic [lobm_pkg::QTY_W-1:0] rem;
    } tent_t;

    typedef enum logic [4:0] {
        S_IDLE, S_TREAD, S_TCHECK, S_INSERT, S_SCAN, S_SCAN_END, S_MATCH,
        S_WRA, S_WRB, S_RMA_RD, S_RMA_WR, S_RMB_RD, S_RMB_WR, S_TRADE,
        S_FIND, S_QUOTE, S_TWR
    } state_t;

    // Book and table memories.
    logic           bk_we [2];
    logic [BW-1:0]  bk_addr [2];
    entry_t         bk_wdata [2];
    logic [EW-1:0]  bk_rdata [2];

    for (genvar s = 0; s < 2; s++)
    begin : g_book
        lobm_ram #(.WIDTH(EW), .DEPTH(BOOK_DEPTH)) u_book (
            .clk(clk), .we(bk_we[s]), .addr(bk_addr[s]),
            .wdata(bk_wdata[s]), .rdata(bk_rdata[s])
        );
    end

    logic          t_we;
    logic [TW-1:0] t_addr;
    tent_t         t_wdata;
    logic [OW-1:0] t_rdata;

    lobm_ram #(.WIDTH(OW), .DEPTH(MAX_MESSAGES)) u_table (
        .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
    );

    state_t            state_reg;
    logic [CW-1:0]     cnt_reg [2];
    logic [IDW-1:0]    nid_reg;
    logic [IDW-1:0]    myid_reg;
    logic [1:0]        op_reg;
    logic [15:0]       qty_reg;
    logic [16:0]       price_reg;
    logic [IDW-1:0]    tgt_reg;
    logic              rej_reg;
    logic [6:0]        nres_reg;
    logic              side_reg;    // side being scanned
    logic              pass_reg;    // 0 bid scan, 1 ask scan
    logic              quote_reg;   // scanning for quote rather than a fill
    logic [CW-1:0]     idx_reg;
    logic              rdv_reg;
    logic [BW-1:0]     rdi_reg;
    entry_t            best_reg [2];
    logic [BW-1:0]     bidx_reg [2];
    logic [21:0]       tot_reg [2];
    logic [15:0]       m_reg;
    logic              tcan_reg;

    entry_t rd;
    assign rd = entry_t'(bk_rdata[side_reg]);

    tent_t trd;
    assign trd = tent_t'(t_rdata);

    logic better;
    always_comb
    begin
        if (rd.price != best_reg[side_reg].price)
        begin
            better = side_reg ? (rd.price < best_reg[side_reg].price)
                              : (rd.price > best_reg[side_reg].price);
        end
        else
        begin
            better = rd.id < best_reg[side_reg].id;
        end
    end

    logic [16:0] cprice;
    always_comb
    begin
        if (limit_price == '0)
        begin
            cprice = 17'd1;
        end
        else if (limit_price > lobm_pkg::TOP_PRICE)
        begin
            cprice = lobm_pkg::TOP_PRICE;
        end
        else
        begin
            cprice = limit_price;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    logic [IDW-1:0] tgt_ext;
    assign tgt_ext = IDW'(cancel_target);

    // Memory port control.
    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            bk_we[s]    = 1'b0;
            bk_addr[s]  = idx_reg[BW-1:0];
            bk_wdata[s] = '0;
        end
        t_we    = 1'b0;
        t_addr  = tgt_reg[TW-1:0] - TW'(1);
        t_wdata = '{side: lobm_pkg::SIDE_NONE, rem: '0};
        unique case (state_reg)
            S_INSERT:
            begin
                bk_we[op_reg[0]]    = 1'b1;
                bk_addr[op_reg[0]]  = cnt_reg[op_reg[0]][BW-1:0];
                bk_wdata[op_reg[0]] = '{id: myid_reg, qty: qty_reg, price: price_reg};
            end
            S_TWR:
            begin
                t_we    = 1'b1;
                t_addr  = myid_reg[TW-1:0] - TW'(1);
                t_wdata = '{side: (op_reg == lobm_pkg::OP_CANCEL) ? lobm_pkg::SIDE_NONE
                                                                : op_reg,
                            rem: qty_reg};
            end
            S_TCHECK:
            begin
                if (tcan_reg)
                begin
                    t_we = 1'b1;
                end
            end
            S_WRA, S_WRB:
            begin
                bk_we[state_reg == S_WRB]    = 1'b1;
                bk_addr[state_reg == S_WRB]  = bidx_reg[state_reg == S_WRB];
                bk_wdata[state_reg == S_WRB] = best_reg[state_reg == S_WRB];
                t_we    = 1'b1;
                t_addr  = best_reg[state_reg == S_WRB].id[TW-1:0] - TW'(1);
                t_wdata = '{side: (state_reg == S_WRB) ? lobm_pkg::SIDE_SELL
                                                       : lobm_pkg::SIDE_BUY,
                            rem: best_reg[state_reg == S_WRB].qty};
            end
            S_RMA_RD, S_RMB_RD:
            begin
                bk_addr[state_reg == S_RMB_RD] =
                    BW'(cnt_reg[state_reg == S_RMB_RD] - CW'(1));
            end
            S_RMA_WR, S_RMB_WR:
            begin
                bk_we[state_reg == S_RMB_WR]    = 1'b1;
                bk_addr[state_reg == S_RMB_WR]  = bidx_reg[state_reg == S_RMB_WR];
                bk_wdata[state_reg == S_RMB_WR] = entry_t'(bk_rdata[state_reg == S_RMB_WR]);
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            nid_reg   <= IDW'(1);
            out_valid <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= operation;
                        price_reg <= cprice;
                        tgt_reg   <= tgt_ext;
                        myid_reg  <= nid_reg;
                        nres_reg  <= '0;
                        tcan_reg  <= 1'b0;
                        if (operation == lobm_pkg::OP_NONE)
                        begin
                            qty_reg   <= quantity;
                            rej_reg   <= 1'b0;
                            state_reg <= S_FIND;
                        end
                        else if (nid_reg > IDW'(MAX_MESSAGES))
                        begin
                            qty_reg   <= quantity;
                            rej_reg   <= 1'b1;
                            state_reg <= S_FIND;
                        end
                        else
                        begin
                            nid_reg   <= nid_reg + IDW'(1);
                            if (operation == lobm_pkg::OP_CANCEL)
                            begin
                                qty_reg <= '0;
                                rej_reg <= 1'b0;
                                if (tgt_ext >= IDW'(1) && tgt_ext < nid_reg)
                                begin
                                    state_reg <= S_TREAD;
                                end
                                else
                                begin
                                    state_reg <= S_TWR;
                                end
                            end
                            else if (quantity == '0)
                            begin
                                qty_reg   <= quantity;
                                rej_reg   <= 1'b0;
                                state_reg <= S_TWR;
                            end
                            else if (cnt_reg[operation[0]] >= CW'(BOOK_DEPTH))
                            begin
                                rej_reg   <= 1'b1;
                                qty_reg   <= '0;
                                state_reg <= S_TWR;
                            end
                            else
                            begin
                                qty_reg   <= quantity;
                                rej_reg   <= 1'b0;
                                state_reg <= S_INSERT;
                            end
                        end
                    end
                end
                S_TREAD:
                begin
                    state_reg <= S_TCHECK;
                    tcan_reg  <= 1'b0;
                end
                S_TCHECK:
                begin
                    if (!tcan_reg)
                    begin
                        if (trd.side != lobm_pkg::SIDE_NONE && trd.rem != '0)
                        begin
                            tcan_reg <= 1'b1;
                            side_reg <= trd.side[0];
                        end
                        else
                        begin
                            state_reg <= S_TWR;
                        end
                    end
                    else
                    begin
                        // Table cleared; search the book for the target id.
                        state_reg <= S_SCAN;
                        quote_reg <= 1'b0;
                        idx_reg   <= '0;
                        rdv_reg   <= 1'b0;
                        bidx_reg[side_reg] <= '0;
                        best_reg[side_reg].id <= '1;
                    end
                end
                S_INSERT:
                begin
                    cnt_reg[op_reg[0]] <= cnt_reg[op_reg[0]] + CW'(1);
                    state_reg <= S_TWR;
                end
                S_TWR:
                begin
                    if (op_reg == lobm_pkg::OP_CANCEL && tcan_reg)
                    begin
                        tcan_reg  <= 1'b0;
                        state_reg <= (side_reg ? S_RMB_RD : S_RMA_RD);
                    end
                    else
                    begin
                        if (op_reg != lobm_pkg::OP_CANCEL && qty_reg != '0)
                        begin
                            quote_reg <= 1'b0;
                        end
                        state_reg <= S_FIND;
                    end
                end
                S_FIND:
                begin
                    // Start the bid pass of a fill or quote scan.
                    quote_reg <= (op_reg == lobm_pkg::OP_CANCEL) || (op_reg == lobm_pkg::OP_NONE) ||
                                 rej_reg || qty_reg == '0 || quote_reg ||
                                 cnt_reg[0] == '0 || cnt_reg[1] == '0 ||
                                 nres_reg == 7'(lobm_pkg::RESULT_LIMIT - 1);
                    pass_reg  <= 1'b0;
                    side_reg  <= 1'b0;
                    idx_reg   <= '0;
                    rdv_reg   <= 1'b0;
                    tot_reg[0] <= '0;
                    tot_reg[1] <= '0;
                    best_reg[0] <= '0;
                    best_reg[1] <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (rdv_reg)
                    begin
                        if (op_reg == lobm_pkg::OP_CANCEL && tcan_reg)
                        begin
                            if (rd.id == tgt_reg)
                            begin
                                bidx_reg[side_reg] <= rdi_reg;
                            end
                        end
                        else if (rdi_reg == '0 || better)
                        begin
                            best_reg[side_reg] <= rd;
                            bidx_reg[side_reg] <= rdi_reg;
                        end
                        if (rdi_reg == '0 || rd.price != best_reg[side_reg].price)
                        begin
                            if (rdi_reg == '0 || better)
                            begin
                                tot_reg[side_reg] <= 22'(rd.qty);
                            end
                        end
                        else
                        begin
                            tot_reg[side_reg] <= tot_reg[side_reg] + 22'(rd.qty);
                        end
                    end
                    rdi_reg <= idx_reg[BW-1:0];
                    if (idx_reg < cnt_reg[side_reg])
                    begin
                        rdv_reg <= 1'b1;
                        idx_reg <= idx_reg + CW'(1);
                    end
                    else
                    begin
                        rdv_reg <= 1'b0;
                        if (!rdv_reg)
                        begin
                            state_reg <= S_SCAN_END;
                        end
                    end
                end
                S_SCAN_END:
                begin
                    if (op_reg == lobm_pkg::OP_CANCEL && tcan_reg)
                    begin
                        state_reg <= S_TWR;
                    end
                    else if (!pass_reg)
                    begin
                        pass_reg  <= 1'b1;
                        side_reg  <= 1'b1;
                        idx_reg   <= '0;
                        rdv_reg   <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                    else if (quote_reg)
                    begin
                        state_reg <= S_QUOTE;
                        out_valid <= 1'b1;
                        kind <= 1'b1;
                        trade_quantity <= '0;
                        trade_price <= '0;
                        bid_total <= (cnt_reg[0] != '0) ? tot_reg[0] : '0;
                        bid_price <= (cnt_reg[0] != '0) ? best_reg[0].price : '0;
                        ask_total <= (cnt_reg[1] != '0) ? tot_reg[1] : '0;
                        ask_price <= (cnt_reg[1] != '0) ? best_reg[1].price
                                                        : lobm_pkg::NO_ASK_PRICE;
                        rejected <= rej_reg;
                        last <= 1'b1;
                    end
                    else if (best_reg[0].price < best_reg[1].price)
                    begin
                        quote_reg <= 1'b1;
                        state_reg <= S_FIND;
                    end
                    else
                    begin
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH:
                begin
                    m_reg <= (best_reg[0].qty < best_reg[1].qty) ? best_reg[0].qty
                                                                 : best_reg[1].qty;
                    out_valid <= 1'b1;
                    kind <= 1'b0;
                    trade_quantity <= (best_reg[0].qty < best_reg[1].qty) ? best_reg[0].qty
                                                                          : best_reg[1].qty;
                    trade_price <= (op_reg == lobm_pkg::OP_BUY) ? best_reg[1].price
                                                                : best_reg[0].price;
                    bid_total <= '0;
                    bid_price <= '0;
                    ask_total <= '0;
                    ask_price <= '0;
                    rejected <= 1'b0;
                    last <= 1'b0;
                    nres_reg <= nres_reg + 7'd1;
                    state_reg <= S_TRADE;
                end
                S_TRADE:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        best_reg[0].qty <= best_reg[0].qty - m_reg;
                        best_reg[1].qty <= best_reg[1].qty - m_reg;
                        state_reg <= S_WRA;
                    end
                end
                S_WRA:
                begin
                    state_reg <= S_WRB;
                end
                S_WRB:
                begin
                    if (best_reg[1].qty == '0)
                    begin
                        side_reg  <= 1'b1;
                        state_reg <= S_RMB_RD;
                    end
                    else if (best_reg[0].qty == '0)
                    begin
                        side_reg  <= 1'b0;
                        state_reg <= S_RMA_RD;
                    end
                    else
                    begin
                        state_reg <= S_FIND;
                    end
                end
                S_RMA_RD:
                begin
                    state_reg <= S_RMA_WR;
                end
                S_RMA_WR:
                begin
                    cnt_reg[0] <= cnt_reg[0] - CW'(1);
                    state_reg <= S_FIND;
                end
                S_RMB_RD:
                begin
                    state_reg <= S_RMB_WR;
                end
                S_RMB_WR:
                begin
                    cnt_reg[1] <= cnt_reg[1] - CW'(1);
                    if (op_reg != lobm_pkg::OP_CANCEL && best_reg[0].qty == '0)
                    begin
                        state_reg <= S_RMA_RD;
                    end
                    else
                    begin
                        state_reg <= S_FIND;
                    end
                end
                S_QUOTE:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/lobm_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Registered read; a read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hw/rtl/lobm_checker.sv =====
// Port-level checker for the limit order book matcher, with its bind.
module lobm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic kind,
    input logic last,
    input logic rejected,
    input logic [15:0] trade_quantity
);

    // A quote always closes the message.
    a_quote_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == last))
        else $error("quote and last disagree");

    // Input is not taken while a result is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");

    // Trades never flag rejection and carry a size.
    a_trade_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind) |-> (!rejected && trade_quantity != '0))
        else $error("bad trade item");

    // Output valid holds until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .last(last),
    .rejected(rejected), .trade_quantity(trade_quantity)
);
